// ----- sv/rational_activation_unit_assert.svh -----
// Assertion macros shared by the rational activation unit RTL.
`ifndef RATIONAL_ACTIVATION_UNIT_ASSERT_SVH
`define RATIONAL_ACTIVATION_UNIT_ASSERT_SVH

`ifndef SYNTH
`define RAU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rau: implication check failed");
`define RAU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rau: next-cycle check failed");
`else
`define RAU_ASSERT_IMP(lbl, ante, cons)
`define RAU_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- sv/rau_pkg.sv -----
// Types, widths and codes of the rational activation unit.
`default_nettype none
package rau_pkg;
    localparam int DATA_W   = 16;
    localparam int FRAC_W   = 12;
    localparam int ACC_W    = 32;
    localparam int CHANNELS = 64;
    localparam int CH_W     = 6;
    localparam int D_W      = DATA_W + 2;      // b - x
    localparam int NUM_W    = 45;              // signed dividend / quotient
    localparam int NMAG_W   = NUM_W - 1;
    localparam int DEN_W    = 34;              // signed divisor
    localparam int DMAG_W   = DEN_W - 2;
    localparam int DIV_CYC  = NMAG_W / 2;      // two quotient bits per cycle
    localparam int CNT_W    = 5;
    localparam int MA_W     = D_W;
    localparam int MB_W     = NUM_W;
    localparam int P_W      = MA_W + MB_W;
    localparam int T_W      = ACC_W + 4;
    localparam int S_W      = T_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 48;

    localparam logic [1:0] FN_FWD  = 2'd0;
    localparam logic [1:0] FN_BWD  = 2'd1;
    localparam logic [1:0] FN_LOAD = 2'd2;
    localparam logic [1:0] FN_READ = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_A  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B_MIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARED  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_B = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP    = 3'd5;

    localparam logic signed [DATA_W-1:0] D_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] D_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0]  A_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]  A_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    // stands in for a saturated term: far outside the accumulator range
    localparam logic signed [T_W-1:0]    T_BIG = {2'b01, {(T_W-2){1'b0}}};

    typedef struct packed {
        logic                     start;
        logic signed [NUM_W-1:0]  num;
        logic signed [DEN_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic                     dz;
        logic signed [NUM_W-1:0]  quot;
    } t_div_res;
endpackage
`default_nettype wire

// ----- sv/rau_ram.sv -----
// Generic single-port-write, registered-read RAM.
`default_nettype none
module rau_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- sv/rau_div.sv -----
// Iterative signed divider, truncating, two quotient bits per cycle.
`default_nettype none
module rau_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rau_pkg::t_div_req i_req,
    output rau_pkg::t_div_res      o_res
);
    import rau_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DMAG_W-1:0]    r_rem;
    logic [NMAG_W-1:0]    r_quo;
    logic [DMAG_W-1:0]    r_den;
    logic                 r_neg;
    logic                 r_dz;
    logic [NUM_W-1:0]     w_nabs;
    logic [DEN_W-1:0]     w_dabs;
    logic [DMAG_W:0]      w_s1;
    logic [DMAG_W:0]      w_s2;

    // returns {new remainder, quotient bit}
    function automatic logic [DMAG_W:0] div_step(input logic [DMAG_W-1:0] rem,
                                                 input logic nbit,
                                                 input logic [DMAG_W-1:0] den);
        logic [DMAG_W:0] t;
        logic [DMAG_W:0] d;
        t = {rem, nbit};
        d = {1'b0, den};
        if (t >= d) begin
            t = t - d;
            return {t[DMAG_W-1:0], 1'b1};
        end
        return {t[DMAG_W-1:0], 1'b0};
    endfunction

    assign w_nabs = i_req.num[NUM_W-1] ? NUM_W'(-i_req.num) : NUM_W'(i_req.num);
    assign w_dabs = i_req.den[DEN_W-1] ? DEN_W'(-i_req.den) : DEN_W'(i_req.den);
    assign w_s1   = div_step(r_rem, r_quo[NMAG_W-1], r_den);
    assign w_s2   = div_step(w_s1[DMAG_W:1], r_quo[NMAG_W-2], r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= w_nabs[NMAG_W-1:0];
                r_den  <= w_dabs[DMAG_W-1:0];
                r_neg  <= i_req.num[NUM_W-1] ^ i_req.den[DEN_W-1];
                r_dz   <= (i_req.den == '0);
            end else if (r_busy) begin
                r_rem <= w_s2[DMAG_W:1];
                r_quo <= {r_quo[NMAG_W-3:0], w_s1[0], w_s2[0]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_CYC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.dz   = r_dz;
    assign o_res.quot = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
endmodule
`default_nettype wire

// ----- sv/rational_activation_unit.sv -----
// Top level of the rational activation unit: control, datapath and state memories.
`default_nettype none
`include "rational_activation_unit_assert.svh"
// One item is in work at a time; the next is taken once the previous result sits in the
// output register. Forward items with x <= 0 and backward items with x < 0 wait on the
// shared iterative divider, the backward ones for up to two divisions. b and c live in
// one RAM, the b-gradient accumulators in another; accumulator entries carry valid bits
// that reset clears, so there is no clearing pass and the block takes items right after
// reset.
module rational_activation_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [rau_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [rau_pkg::DATA_W-1:0]      i_cfg_data,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // channel[5:0], value_x[21:6], value_y[37:22], grad_in[53:38],
    // new_b[69:54], new_c[85:70], zero[87:86]
    input  wire logic [rau_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // func[1:0]
    input  wire logic [1:0]                      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // result_value[15:0], grad_b_out[47:16]
    output logic [rau_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // fault[0] (division by zero or saturation)
    output logic                                 m_axis_tuser
);
    import rau_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_FETCH, S_FNMUL, S_FNDIV, S_FNWAIT, S_PMUL, S_PFIN,
        S_QDIV, S_QWAIT, S_QMUL, S_ACC, S_BPROP, S_YBMUL, S_XDMUL,
        S_RDIV, S_RWAIT, S_RMUL, S_RFIN, S_OUT
    } t_state;

    t_state                     r_state;
    logic signed [DATA_W-1:0]   r_gain, r_bmin, r_bmax;
    logic                       r_shared, r_learn, r_prop;
    logic [CHANNELS-1:0]        r_accv;
    logic [CH_W-1:0]            r_ch;
    logic [1:0]                 r_func;
    logic signed [DATA_W-1:0]   r_x, r_y, r_g, r_nb, r_nc, r_b, r_c;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [P_W-1:0]      r_prod;
    logic signed [NUM_W-1:0]    r_num, r_q;
    logic                       r_qz, r_nz, r_nneg;
    logic signed [DATA_W-1:0]   r_res;
    logic signed [ACC_W-1:0]    r_gout;
    logic                       r_f;
    logic                       r_mvalid;
    logic [OUT_DATA_W-1:0]      r_mdata;
    logic                       r_mf;

    logic [CH_W-1:0]            w_ch_in;
    logic                       w_accept;
    logic [2*DATA_W-1:0]        w_bc_rdata, w_bc_wdata;
    logic                       w_bc_we;
    logic [ACC_W-1:0]           w_acc_rdata;
    logic                       w_acc_we;
    logic signed [DATA_W-1:0]   w_braw, w_bcl;
    logic signed [D_W-1:0]      w_d;
    logic signed [MA_W-1:0]     w_ma;
    logic signed [MB_W-1:0]     w_mb;
    logic signed [P_W-1:0]      w_prod, w_sh;
    logic [DATA_W:0]            w_psat;
    logic [DATA_W:0]            w_qsat;
    logic signed [NUM_W-1:0]    w_qnum;
    logic signed [T_W-1:0]      w_t;
    logic signed [S_W-1:0]      w_sum;
    logic signed [ACC_W-1:0]    w_sum_sat;
    logic                       w_sum_f;
    logic signed [DATA_W-1:0]   w_huge16;
    t_div_req                   w_dreq;
    t_div_res                   w_dres;

    // {saturated flag, value}
    function automatic logic [DATA_W:0] sat_data(input logic signed [P_W-1:0] v);
        if (v > P_W'(D_MAX)) begin
            return {1'b1, D_MAX};
        end
        if (v < P_W'(D_MIN)) begin
            return {1'b1, D_MIN};
        end
        return {1'b0, v[DATA_W-1:0]};
    endfunction

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_ch_in       = r_shared ? '0 : s_axis_tdata[CH_W-1:0];

    rau_ram #(.WIDTH(2*DATA_W), .DEPTH(CHANNELS)) u_bc_ram (
        .i_clk   (i_clk),
        .i_we    (w_bc_we),
        .i_waddr (r_ch),
        .i_wdata (w_bc_wdata),
        .i_raddr (w_ch_in),
        .o_rdata (w_bc_rdata)
    );

    rau_ram #(.WIDTH(ACC_W), .DEPTH(CHANNELS)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc_we),
        .i_waddr (r_ch),
        .i_wdata (w_sum_sat),
        .i_raddr (w_ch_in),
        .o_rdata (w_acc_rdata)
    );

    rau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_res   (w_dres)
    );

    // b limited to b_max first, then raised to b_min
    assign w_braw = w_bc_rdata[2*DATA_W-1:DATA_W];
    always_comb begin
        w_bcl = w_braw;
        if (w_bcl > r_bmax) begin
            w_bcl = r_bmax;
        end
        if (w_bcl < r_bmin) begin
            w_bcl = r_bmin;
        end
    end

    assign w_bc_we    = (r_state == S_FETCH) && (r_func == FN_FWD || r_func == FN_LOAD);
    assign w_bc_wdata = (r_func == FN_LOAD) ? {r_nb, r_nc}
                                            : {w_bcl, w_bc_rdata[DATA_W-1:0]};
    // the saturated sum goes straight into the accumulator RAM
    assign w_acc_we   = (r_state == S_ACC);

    assign w_d    = D_W'(r_b) - D_W'(r_x);
    assign w_qnum = -(NUM_W'(r_y) <<< FRAC_W);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_FNMUL: begin
                w_ma = MA_W'(r_gain);
                w_mb = MB_W'(r_x);
            end
            S_PMUL: begin
                w_ma = (r_func == FN_FWD) ? MA_W'(r_x) : MA_W'(r_g);
                w_mb = MB_W'(r_c);
            end
            S_QMUL, S_RMUL: begin
                w_ma = MA_W'(r_g);
                w_mb = r_q;
            end
            S_YBMUL: begin
                w_ma = MA_W'(r_y);
                w_mb = MB_W'(r_b);
            end
            S_XDMUL: begin
                w_ma = w_d;
                w_mb = MB_W'(r_x);
            end
            default: begin
            end
        endcase
    end
    assign w_prod = w_ma * w_mb;
    assign w_sh   = r_prod >>> FRAC_W;
    assign w_psat = sat_data(w_sh);
    assign w_qsat = sat_data(P_W'(w_dres.quot));

    // saturated product of g and a saturated quotient
    assign w_huge16 = (r_nneg ^ r_g[DATA_W-1]) ? D_MIN : D_MAX;

    always_comb begin
        if (r_qz) begin
            if (r_nz && r_g != '0) begin
                w_t = (r_nneg ^ r_g[DATA_W-1]) ? -T_BIG : T_BIG;
            end else begin
                w_t = '0;
            end
        end else begin
            w_t = T_W'(w_sh);
        end
        w_sum = S_W'(r_acc) + S_W'(w_t);
        w_sum_f = 1'b0;
        if (w_sum > S_W'(A_MAX)) begin
            w_sum_sat = A_MAX;
            w_sum_f   = 1'b1;
        end else if (w_sum < S_W'(A_MIN)) begin
            w_sum_sat = A_MIN;
            w_sum_f   = 1'b1;
        end else begin
            w_sum_sat = w_sum[ACC_W-1:0];
        end
    end

    always_comb begin
        w_dreq = '0;
        case (r_state)
            S_FNDIV: begin
                w_dreq.start = 1'b1;
                w_dreq.num   = NUM_W'(r_prod);
                w_dreq.den   = DEN_W'(w_d);
            end
            S_QDIV: begin
                w_dreq.start = 1'b1;
                w_dreq.num   = w_qnum;
                w_dreq.den   = DEN_W'(w_d);
            end
            S_RDIV: begin
                w_dreq.start = 1'b1;
                w_dreq.num   = r_num;
                w_dreq.den   = DEN_W'(r_prod);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_gain   <= DATA_W'(1 << FRAC_W);
            r_bmin   <= '0;
            r_bmax   <= D_MAX;
            r_shared <= 1'b0;
            r_learn  <= 1'b1;
            r_prop   <= 1'b1;
            r_accv   <= '0;
            r_mvalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_GAIN_A:  r_gain   <= i_cfg_data;
                    CFG_B_MIN:   r_bmin   <= i_cfg_data;
                    CFG_B_MAX:   r_bmax   <= i_cfg_data;
                    CFG_SHARED:  r_shared <= i_cfg_data[0];
                    CFG_LEARN_B: r_learn  <= i_cfg_data[0];
                    CFG_PROP:    r_prop   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            // S_OUT reloads the output register itself
            if (m_axis_tvalid && m_axis_tready && r_state != S_OUT) begin
                r_mvalid <= 1'b0;
            end
            if (w_acc_we) begin
                r_accv[r_ch] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_func  <= s_axis_tuser;
                        r_ch    <= w_ch_in;
                        r_x     <= s_axis_tdata[21:6];
                        r_y     <= s_axis_tdata[37:22];
                        r_g     <= s_axis_tdata[53:38];
                        r_nb    <= s_axis_tdata[69:54];
                        r_nc    <= s_axis_tdata[85:70];
                        r_res   <= '0;
                        r_gout  <= '0;
                        r_f     <= 1'b0;
                        r_qz    <= 1'b0;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_c   <= w_bc_rdata[DATA_W-1:0];
                    r_acc <= r_accv[r_ch] ? w_acc_rdata : '0;
                    case (r_func)
                        FN_FWD: begin
                            r_b     <= w_bcl;
                            r_state <= r_x[DATA_W-1] || r_x == '0 ? S_FNMUL : S_PMUL;
                        end
                        FN_BWD: begin
                            r_b     <= w_braw;
                            r_state <= (r_learn && r_x[DATA_W-1]) ? S_QDIV : S_BPROP;
                        end
                        FN_LOAD: begin
                            r_state <= S_OUT;
                        end
                        default: begin
                            r_gout       <= r_accv[r_ch] ? w_acc_rdata : '0;
                            r_accv[r_ch] <= 1'b0;
                            r_state      <= S_OUT;
                        end
                    endcase
                end
                S_FNMUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_FNDIV;
                end
                S_FNDIV, S_QDIV, S_RDIV: begin
                    r_nz    <= (w_dreq.num != '0);
                    r_nneg  <= w_dreq.num[NUM_W-1];
                    r_state <= (r_state == S_FNDIV) ? S_FNWAIT
                             : (r_state == S_QDIV) ? S_QWAIT : S_RWAIT;
                end
                S_FNWAIT: begin
                    if (w_dres.done) begin
                        if (w_dres.dz) begin
                            r_f   <= 1'b1;
                            r_res <= !r_nz ? '0 : (r_nneg ? D_MIN : D_MAX);
                        end else begin
                            r_f   <= r_f | w_qsat[DATA_W];
                            r_res <= w_qsat[DATA_W-1:0];
                        end
                        r_state <= S_OUT;
                    end
                end
                S_PMUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_PFIN;
                end
                S_PFIN: begin
                    r_f     <= r_f | w_psat[DATA_W];
                    r_res   <= w_psat[DATA_W-1:0];
                    r_state <= S_OUT;
                end
                S_QWAIT, S_RWAIT: begin
                    if (w_dres.done) begin
                        r_qz <= w_dres.dz;
                        r_q  <= w_dres.quot;
                        if (w_dres.dz) begin
                            r_f <= 1'b1;
                        end
                        r_state <= (r_state == S_QWAIT) ? S_QMUL : S_RMUL;
                    end
                end
                S_QMUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_f       <= r_f | w_sum_f;
                    r_state   <= S_BPROP;
                end
                S_BPROP: begin
                    if (!r_prop) begin
                        r_state <= S_OUT;
                    end else if (!r_x[DATA_W-1]) begin
                        r_state <= S_PMUL;
                    end else begin
                        r_state <= S_YBMUL;
                    end
                end
                S_YBMUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_XDMUL;
                end
                S_XDMUL: begin
                    r_num   <= NUM_W'(r_prod) <<< FRAC_W;
                    r_prod  <= w_prod;
                    r_state <= S_RDIV;
                end
                S_RMUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_RFIN;
                end
                S_RFIN: begin
                    if (r_qz) begin
                        r_res <= (r_nz && r_g != '0) ? w_huge16 : '0;
                    end else begin
                        r_f   <= r_f | w_psat[DATA_W];
                        r_res <= w_psat[DATA_W-1:0];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_mvalid || m_axis_tready) begin
                        r_mvalid <= 1'b1;
                        r_mdata  <= {r_gout, r_res};
                        r_mf     <= r_f;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tuser  = r_mf;

    `RAU_ASSERT_NXT(a_accept_fetch, w_accept, r_state == S_FETCH)
    `RAU_ASSERT_IMP(a_div_done_wait, w_dres.done,
        r_state == S_FNWAIT || r_state == S_QWAIT || r_state == S_RWAIT)
    `RAU_ASSERT_IMP(a_out_from_out, m_axis_tvalid && !$past(m_axis_tvalid),
        $past(r_state == S_OUT))
    `RAU_ASSERT_NXT(a_acc_write_valid, w_acc_we, r_accv[$past(r_ch)])
endmodule
`default_nettype wire
